// ===== rtl/socks5_handshake_engine_top_defines.svh =====
// assertion macros shared by the rtl
`ifndef SOCKS5_HANDSHAKE_ENGINE_TOP_DEFINES_SVH
`define SOCKS5_HANDSHAKE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define S5HE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s5he implication check failed");

// next-cycle implication, off during reset
`define S5HE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s5he next-cycle check failed");

`endif

// ===== rtl/s5he_pkg.sv =====
package s5he_pkg;

  localparam logic [2:0] PH_GREET   = 3'd0;
  localparam logic [2:0] PH_REQUEST = 3'd1;
  localparam logic [2:0] PH_RESOLVE = 3'd2;
  localparam logic [2:0] PH_CONNECT = 3'd3;
  localparam logic [2:0] PH_ESTAB   = 3'd4;
  localparam logic [2:0] PH_CLOSED  = 3'd5;

  localparam logic [2:0] K_REPLY   = 3'd0;
  localparam logic [2:0] K_CONN    = 3'd1;
  localparam logic [2:0] K_DOMAIN  = 3'd2;
  localparam logic [2:0] K_RESOLVE = 3'd3;
  localparam logic [2:0] K_PAYLOAD = 3'd4;
  localparam logic [2:0] K_CLOSE   = 3'd5;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_CONNECT = 2'd2;
  localparam logic [1:0] ACT_END     = 2'd3;

  localparam logic [1:0] OC_OK      = 2'd0;
  localparam logic [1:0] OC_REFUSED = 2'd2;

  localparam logic [7:0] VER5        = 8'd5;
  localparam logic [7:0] CMD_CONNECT = 8'd1;
  localparam logic [7:0] AT_IPV4     = 8'd1;
  localparam logic [7:0] AT_DOMAIN   = 8'd3;
  localparam logic [7:0] AT_IPV6     = 8'd4;

  localparam logic [7:0] REP_OK      = 8'd0;
  localparam logic [7:0] REP_FAIL    = 8'd1;
  localparam logic [7:0] REP_REFUSED = 8'd5;

  localparam logic [9:0] LEN_IPV4 = 10'd10;
  localparam logic [9:0] LEN_IPV6 = 10'd22;

  // last beat of each reply burst; beat ten is the close
  localparam logic [3:0] END_ACK   = 4'd1;
  localparam logic [3:0] END_REPLY = 4'd9;
  localparam logic [3:0] END_CLOSE = 4'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [1:0]  outcome_code;
    logic [31:0] resolved_address;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic        is_reply;
    logic [3:0]  end_beat;
    logic [7:0]  rep;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [15:0] port;
    logic        early;
  } desc_t;

  typedef struct packed {
    logic [2:0] phase;
  } status_t;

  function automatic desc_t mk_single(input logic [2:0] kind, input logic [7:0] data,
                                      input logic [31:0] addr, input logic [15:0] port,
                                      input logic early);
    desc_t d;
    d          = '0;
    d.valid    = 1'b1;
    d.kind     = kind;
    d.data     = data;
    d.addr     = addr;
    d.port     = port;
    d.early    = early;
    return d;
  endfunction

  function automatic desc_t mk_reply(input logic [7:0] rep, input logic [3:0] end_beat);
    desc_t d;
    d          = '0;
    d.valid    = 1'b1;
    d.is_reply = 1'b1;
    d.rep      = rep;
    d.end_beat = end_beat;
    return d;
  endfunction

endpackage

// ===== rtl/s5he_in_if.sv =====
interface s5he_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [1:0]  outcome_code;
  logic [31:0] resolved_address;

  modport source (output valid, action, data_byte, outcome_code, resolved_address,
                  input ready);
  modport sink (input valid, action, data_byte, outcome_code, resolved_address,
                output ready);
endinterface

// ===== rtl/s5he_out_if.sv =====
interface s5he_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] target_address;
  logic [15:0] dest_port;
  logic        early;
  logic        last;

  modport source (output valid, kind, out_byte, target_address, dest_port, early, last,
                  input ready);
  modport sink (input valid, kind, out_byte, target_address, dest_port, early, last,
                output ready);
endinterface

// ===== rtl/s5he_parser.sv =====
module s5he_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  s5he_pkg::in_item_t  item,
  output s5he_pkg::desc_t     desc,
  output s5he_pkg::status_t   status
);

  logic [2:0]  phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  method_count, method_count_next;
  logic        header_ok, header_ok_next;
  logic [7:0]  address_type, address_type_next;
  logic [7:0]  name_length, name_length_next;
  logic [31:0] address_accum, address_accum_next;
  logic [15:0] port_accum, port_accum_next;

  logic [8:0]  bc_inc;
  logic [9:0]  idx;
  logic [7:0]  b;
  logic [7:0]  mc;
  logic [9:0]  need;
  logic [15:0] port_shift;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    method_count_next  = method_count;
    header_ok_next     = header_ok;
    address_type_next  = address_type;
    name_length_next   = name_length;
    address_accum_next = address_accum;
    port_accum_next    = port_accum;
    desc               = '0;
    b          = item.data_byte;
    bc_inc     = byte_count + 9'd1;
    idx        = {1'b0, byte_count};
    mc         = (byte_count == 9'd1) ? b : method_count;
    port_shift = {port_accum[7:0], b};
    need       = s5he_pkg::LEN_IPV6;
    if (address_type == s5he_pkg::AT_IPV4) begin
      need = s5he_pkg::LEN_IPV4;
    end else if (address_type == s5he_pkg::AT_DOMAIN) begin
      need = 10'd7 + {2'b00, name_length};
    end

    if (phase <= s5he_pkg::PH_ESTAB) begin
      case (item.action)
        s5he_pkg::ACT_END: begin
          phase_next = s5he_pkg::PH_CLOSED;
          desc = s5he_pkg::mk_single(s5he_pkg::K_CLOSE, 8'd0, 32'd0, 16'd0, 1'b0);
        end
        s5he_pkg::ACT_BYTE: begin
          if (phase == s5he_pkg::PH_GREET) begin
            byte_count_next = bc_inc;
            method_count_next = mc;
            if (byte_count != 9'd0 && {1'b0, bc_inc} == 10'd2 + {2'b00, mc}) begin
              desc = s5he_pkg::mk_reply(s5he_pkg::REP_OK, s5he_pkg::END_ACK);
              phase_next = s5he_pkg::PH_REQUEST;
              byte_count_next = 9'd0;
              header_ok_next = 1'b0;
              address_accum_next = 32'd0;
              port_accum_next = 16'd0;
            end
          end else if (phase == s5he_pkg::PH_REQUEST) begin
            byte_count_next = bc_inc;
            if (idx == 10'd0) begin
              header_ok_next = (b == s5he_pkg::VER5);
            end else if (idx == 10'd1) begin
              header_ok_next = header_ok && (b == s5he_pkg::CMD_CONNECT);
            end else if (idx == 10'd2) begin
              header_ok_next = header_ok;
            end else if (idx == 10'd3) begin
              address_type_next = b;
              if (!header_ok || (b != s5he_pkg::AT_IPV4 && b != s5he_pkg::AT_DOMAIN &&
                                 b != s5he_pkg::AT_IPV6)) begin
                phase_next = s5he_pkg::PH_CLOSED;
                desc = s5he_pkg::mk_reply(s5he_pkg::REP_FAIL, s5he_pkg::END_CLOSE);
              end
            end else if (address_type == s5he_pkg::AT_DOMAIN && idx == 10'd4) begin
              name_length_next = b;
            end else if (address_type == s5he_pkg::AT_DOMAIN &&
                         idx < 10'd5 + {2'b00, name_length}) begin
              desc = s5he_pkg::mk_single(s5he_pkg::K_DOMAIN, b, 32'd0, 16'd0, 1'b0);
            end else begin
              if (address_type == s5he_pkg::AT_IPV4 && idx < 10'd8) begin
                address_accum_next = {address_accum[23:0], b};
              end
              if (idx + 10'd2 >= need) begin
                port_accum_next = port_shift;
              end
              if (idx + 10'd1 == need) begin
                if (address_type == s5he_pkg::AT_IPV4) begin
                  phase_next = s5he_pkg::PH_CONNECT;
                  desc = s5he_pkg::mk_single(s5he_pkg::K_CONN, 8'd0, address_accum,
                                             port_accum_next, 1'b0);
                end else if (address_type == s5he_pkg::AT_DOMAIN) begin
                  phase_next = s5he_pkg::PH_RESOLVE;
                  desc = s5he_pkg::mk_single(s5he_pkg::K_RESOLVE, 8'd0, 32'd0,
                                             port_accum_next, 1'b0);
                end else begin
                  phase_next = s5he_pkg::PH_CLOSED;
                  desc = s5he_pkg::mk_reply(s5he_pkg::REP_FAIL, s5he_pkg::END_CLOSE);
                end
              end
            end
          end else begin
            desc = s5he_pkg::mk_single(s5he_pkg::K_PAYLOAD, b, 32'd0, 16'd0,
                                       phase != s5he_pkg::PH_ESTAB);
          end
        end
        s5he_pkg::ACT_RESOLVE: begin
          if (phase == s5he_pkg::PH_RESOLVE) begin
            if (item.outcome_code != s5he_pkg::OC_OK || item.resolved_address == 32'd0) begin
              phase_next = s5he_pkg::PH_CLOSED;
              desc = s5he_pkg::mk_reply(s5he_pkg::REP_FAIL, s5he_pkg::END_CLOSE);
            end else begin
              address_accum_next = item.resolved_address;
              phase_next = s5he_pkg::PH_CONNECT;
              desc = s5he_pkg::mk_single(s5he_pkg::K_CONN, 8'd0, item.resolved_address,
                                         port_accum, 1'b0);
            end
          end
        end
        default: begin
          if (phase == s5he_pkg::PH_CONNECT) begin
            if (item.outcome_code == s5he_pkg::OC_OK) begin
              phase_next = s5he_pkg::PH_ESTAB;
              desc = s5he_pkg::mk_reply(s5he_pkg::REP_OK, s5he_pkg::END_REPLY);
            end else begin
              phase_next = s5he_pkg::PH_CLOSED;
              desc = s5he_pkg::mk_reply((item.outcome_code == s5he_pkg::OC_REFUSED) ?
                                        s5he_pkg::REP_REFUSED : s5he_pkg::REP_FAIL,
                                        s5he_pkg::END_CLOSE);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= s5he_pkg::PH_GREET;
      byte_count    <= 9'd0;
      method_count  <= 8'd0;
      header_ok     <= 1'b0;
      address_type  <= 8'd0;
      name_length   <= 8'd0;
      address_accum <= 32'd0;
      port_accum    <= 16'd0;
    end else if (take) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      method_count  <= method_count_next;
      header_ok     <= header_ok_next;
      address_type  <= address_type_next;
      name_length   <= name_length_next;
      address_accum <= address_accum_next;
      port_accum    <= port_accum_next;
    end
  end

  assign status.phase = phase;

endmodule

// ===== rtl/s5he_emitter.sv =====
module s5he_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  s5he_pkg::desc_t   desc,
  output logic              free,
  s5he_out_if.source        out_ch
);

  logic            busy;
  logic [3:0]      beat;
  s5he_pkg::desc_t cur;
  logic            at_end;
  logic            fire;

  assign at_end = (beat == cur.end_beat);
  assign fire   = busy && out_ch.ready;
  assign free   = !busy || (out_ch.ready && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      beat <= 4'd0;
    end else if (fire) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= desc;
    end
  end

  always_comb begin
    out_ch.valid          = busy;
    out_ch.last           = at_end;
    out_ch.kind           = cur.kind;
    out_ch.out_byte       = cur.data;
    out_ch.target_address = cur.addr;
    out_ch.dest_port      = cur.port;
    out_ch.early          = cur.early;
    if (cur.is_reply) begin
      out_ch.kind           = s5he_pkg::K_REPLY;
      out_ch.target_address = 32'd0;
      out_ch.dest_port      = 16'd0;
      out_ch.early          = 1'b0;
      case (beat)
        4'd0:    out_ch.out_byte = s5he_pkg::VER5;
        4'd1:    out_ch.out_byte = cur.rep;
        4'd3:    out_ch.out_byte = s5he_pkg::AT_IPV4;
        4'd10: begin
          out_ch.kind     = s5he_pkg::K_CLOSE;
          out_ch.out_byte = 8'd0;
        end
        default: out_ch.out_byte = 8'd0;
      endcase
    end
  end

endmodule

// ===== rtl/socks5_handshake_engine_top.sv =====
// channel  | dir | payload                                                      | items
// in_ch    | in  | action, data_byte, outcome_code, resolved_address            | bytes, events
// out_ch   | out | kind, out_byte, target_address, dest_port, early, last       | results
//
// one item per cycle enters the input register and is parsed in a single pass
// results leave the emitter one per cycle while out_ch is ready; replies are 2 to 11 bytes
// an item is parsed only when the emitter can take its results, so bursts stall input
// rst is synchronous and returns the parser to the greeting phase
`include "socks5_handshake_engine_top_defines.svh"

module socks5_handshake_engine_top (
  input  logic        clk,
  input  logic        rst,
  s5he_in_if.sink     in_ch,
  s5he_out_if.source  out_ch
);

  logic                in_v;
  s5he_pkg::in_item_t  item;
  s5he_pkg::desc_t     desc;
  s5he_pkg::status_t   status;
  logic                free;
  logic                advance;
  logic                load;
  logic                close_out;
  logic                phase_closed;
  logic                phase_after_greet;

  assign advance     = in_v && free;
  assign load        = advance && desc.valid;
  assign in_ch.ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.action           <= in_ch.action;
      item.data_byte        <= in_ch.data_byte;
      item.outcome_code     <= in_ch.outcome_code;
      item.resolved_address <= in_ch.resolved_address;
    end
  end

  s5he_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .item   (item),
    .desc   (desc),
    .status (status)
  );

  s5he_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .desc   (desc),
    .free   (free),
    .out_ch (out_ch)
  );

  assign close_out         = out_ch.valid && (out_ch.kind == s5he_pkg::K_CLOSE);
  assign phase_closed      = (status.phase == s5he_pkg::PH_CLOSED);
  assign phase_after_greet = (status.phase == s5he_pkg::PH_GREET) ||
                             (status.phase == s5he_pkg::PH_REQUEST) || phase_closed;

  `S5HE_ASSERT_IMP(a_close_is_last, close_out, out_ch.last)
  `S5HE_ASSERT_NXT(a_closed_sticky, phase_closed, phase_closed)
  `S5HE_ASSERT_NXT(a_greet_exit, status.phase == s5he_pkg::PH_GREET, phase_after_greet)

endmodule
